### rtl/tot_pkg.sv
package tot_pkg;

  localparam int DEV_W      = 52;   // device, arrival and result time
  localparam int OFS_W      = 54;   // measured and tracked offset, signed
  localparam int FIX_W      = 53;   // fixed offset, signed
  localparam int SCAN_W     = 24;
  localparam int WGT_W      = 16;   // Q0.16 weight
  localparam int DLY_W      = 31;   // capture delay, signed
  localparam int DIFF_FULL_W = OFS_W + 1;
  localparam int DIFF_W     = 22;   // enough for |diff| <= 1 s in us
  localparam int PROD_W     = DIFF_W + WGT_W + 1;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = PROD_W - FRAC_W;
  localparam int SUM_W      = 57;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 53;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 56;

  localparam logic [DEV_W:0]               STEP_BACK_US = 53'd500000;
  localparam logic signed [DIFF_FULL_W-1:0] JUMP_POS    = 55'sd1000000;
  localparam logic signed [DIFF_FULL_W-1:0] JUMP_NEG    = -55'sd1000000;
  localparam logic signed [PROD_W-1:0]      ROUND_HALF  = 39'sd32768;

  localparam logic signed [FIX_W-1:0] FIXED_OFFSET_RST  = 53'sd1739510486944657;
  localparam logic [SCAN_W-1:0]       SCAN_SPAN_RST     = 24'd100000;
  localparam logic [WGT_W-1:0]        SMOOTH_WEIGHT_RST = 16'd655;
  localparam logic signed [DLY_W-1:0] CAPTURE_DELAY_RST = 31'sd32430;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_OFFSET  = 3'd0,
    CFG_AUTO_MODE     = 3'd1,
    CFG_SCAN_SPAN     = 3'd2,
    CFG_SMOOTH_WEIGHT = 3'd3,
    CFG_CAPTURE_DELAY = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [OFS_W-1:0] measured;   // two's complement
  } s1_item_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [OFS_W-1:0] eff;        // two's complement
    logic             reseeded;
  } s2_item_t;

  typedef struct packed {
    logic tracked_valid;
  } trk_stat_t;

endpackage

### rtl/tot_in_stage.sv
module tot_in_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tot_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [tot_pkg::SCAN_W-1:0]       scan_span,
  input  logic                             nxt_ready,
  output logic                             s1_valid,
  output tot_pkg::s1_item_t                s1_item
);

  logic                      valid_r;
  tot_pkg::s1_item_t         item_r;
  tot_pkg::s1_item_t         item_nxt;
  logic [tot_pkg::DEV_W-1:0] dev;
  logic [tot_pkg::DEV_W-1:0] arr;

  assign dev = in_data[tot_pkg::DEV_W-1:0];
  assign arr = in_data[2*tot_pkg::DEV_W-1:tot_pkg::DEV_W];

  // arrival - device - scan span, fits 54 bits signed
  always_comb begin
    item_nxt.dev      = dev;
    item_nxt.measured = {2'b00, arr} - {2'b00, dev}
                        - {{(tot_pkg::OFS_W-tot_pkg::SCAN_W){1'b0}}, scan_span};
  end

  assign in_ready = !valid_r || nxt_ready;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

### rtl/tot_offset_track.sv
module tot_offset_track (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  output logic                           s1_ready,
  input  tot_pkg::s1_item_t              s1_item,
  input  logic                           auto_mode,
  input  logic [tot_pkg::FIX_W-1:0]      fixed_offset,
  input  logic [tot_pkg::WGT_W-1:0]      smoothing_weight,
  input  logic                           nxt_ready,
  output logic                           s2_valid,
  output tot_pkg::s2_item_t              s2_item,
  output tot_pkg::trk_stat_t             stat
);

  logic                                   valid_r;
  tot_pkg::s2_item_t                      item_r;
  tot_pkg::s2_item_t                      item_nxt;
  logic                                   tracked_valid_r;
  logic signed [tot_pkg::OFS_W-1:0]       tracked_r;
  logic signed [tot_pkg::OFS_W-1:0]       tracked_nxt;
  logic [tot_pkg::DEV_W-1:0]              prev_dev_r;
  logic                                   load;
  logic signed [tot_pkg::OFS_W-1:0]       measured;
  logic signed [tot_pkg::DIFF_FULL_W-1:0] diff;
  logic signed [tot_pkg::DIFF_W-1:0]      diff_n;
  logic signed [tot_pkg::PROD_W-1:0]      prod;
  logic signed [tot_pkg::PROD_W-1:0]      rounded;
  logic signed [tot_pkg::STEP_W-1:0]      step;
  logic signed [tot_pkg::OFS_W-1:0]       averaged;
  logic                                   step_back;
  logic                                   jumped;
  logic                                   reseed;

  assign load     = s1_valid && s1_ready;
  assign measured = $signed(s1_item.measured);

  assign step_back = tracked_valid_r &&
                     (({1'b0, s1_item.dev} + tot_pkg::STEP_BACK_US) < {1'b0, prev_dev_r});
  assign diff      = $signed({measured[tot_pkg::OFS_W-1], measured})
                     - $signed({tracked_r[tot_pkg::OFS_W-1], tracked_r});
  assign jumped    = tracked_valid_r && (diff > tot_pkg::JUMP_POS || diff < tot_pkg::JUMP_NEG);
  assign reseed    = !tracked_valid_r || step_back || jumped;

  // diff is within one second whenever the average is used
  assign diff_n   = diff[tot_pkg::DIFF_W-1:0];
  assign prod     = $signed({1'b0, smoothing_weight}) * diff_n;
  assign rounded  = prod + tot_pkg::ROUND_HALF;
  assign step     = rounded[tot_pkg::PROD_W-1:tot_pkg::FRAC_W];   // floor divide by 65536
  assign averaged = tracked_r
                    + {{(tot_pkg::OFS_W-tot_pkg::STEP_W){step[tot_pkg::STEP_W-1]}}, step};

  assign tracked_nxt = reseed ? measured : averaged;

  always_comb begin
    item_nxt.dev      = s1_item.dev;
    item_nxt.eff      = auto_mode ? tracked_nxt
                                  : {fixed_offset[tot_pkg::FIX_W-1], fixed_offset};
    item_nxt.reseeded = auto_mode && reseed;
  end

  assign s1_ready           = !valid_r || nxt_ready;
  assign s2_valid           = valid_r;
  assign s2_item            = item_r;
  assign stat.tracked_valid = tracked_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r         <= 1'b0;
      tracked_valid_r <= 1'b0;
      tracked_r       <= '0;
      prev_dev_r      <= '0;
    end else begin
      if (s1_ready) begin
        valid_r <= s1_valid;
      end
      if (load && auto_mode) begin
        tracked_valid_r <= 1'b1;
        tracked_r       <= tracked_nxt;
        prev_dev_r      <= s1_item.dev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

### rtl/tot_out_stage.sv
module tot_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s2_valid,
  output logic                           s2_ready,
  input  tot_pkg::s2_item_t              s2_item,
  input  logic [tot_pkg::DLY_W-1:0]      capture_delay,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tot_pkg::DEV_W-1:0]      out_time,
  output logic                           out_reseeded
);

  logic                              valid_r;
  logic [tot_pkg::DEV_W-1:0]         time_r;
  logic [tot_pkg::DEV_W-1:0]         time_nxt;
  logic                              reseeded_r;
  logic signed [tot_pkg::SUM_W-1:0]  sum;

  assign sum = $signed({{(tot_pkg::SUM_W-tot_pkg::DEV_W){1'b0}}, s2_item.dev})
             + $signed({{(tot_pkg::SUM_W-tot_pkg::OFS_W){s2_item.eff[tot_pkg::OFS_W-1]}},
                        s2_item.eff})
             + $signed({{(tot_pkg::SUM_W-tot_pkg::DLY_W){capture_delay[tot_pkg::DLY_W-1]}},
                        capture_delay});

  // clamp at zero, saturate at the top of the time range
  always_comb begin
    if (sum[tot_pkg::SUM_W-1]) begin
      time_nxt = '0;
    end else if (|sum[tot_pkg::SUM_W-2:tot_pkg::DEV_W]) begin
      time_nxt = '1;
    end else begin
      time_nxt = sum[tot_pkg::DEV_W-1:0];
    end
  end

  assign s2_ready     = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_time     = time_r;
  assign out_reseeded = reseeded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      time_r     <= time_nxt;
      reseeded_r <= s2_item.reseeded;
    end
  end

endmodule

### rtl/timestamp_offset_tracker.sv
// timestamp_offset_tracker: turns a device timestamp into host time, every value being
// a count of microseconds. With auto_mode clear the configured fixed offset is added;
// with auto_mode set the offset is measured per item as arrival minus device time minus
// the scan span and smoothed by an exponential moving average (Q0.16 weight, rounded to
// nearest). The average restarts from the measured offset on the first item, when the
// device clock goes back by more than 0.5 s, or when the measured offset is more than
// 1 s away from the average; out_tuser flags such an item. The capture delay is added
// last and the result is clamped to 0 .. 2^52-1. The block takes one item per clock while
// the output does not stall, and each result passes the input register, the offset
// tracking register and the output register in turn; the rate is set by the offset
// average, which updates once per item through a single 16 x 22 bit multiply-add
// feeding its own register. Stages hold their item when the output stalls, and fill up
// behind a stalled result before in_tready drops. Configuration is written through
// cfg_wr_en / cfg_index / cfg_data while no item is in flight.
module timestamp_offset_tracker (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [51:0] device_time, [103:52] arrival_time
  input  logic [tot_pkg::IN_DATA_W-1:0]     in_tdata,

  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [51:0] shifted_time, [55:52] zero
  output logic [tot_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] offset_reseeded
  output logic [0:0]                        out_tuser,

  input  logic                              cfg_wr_en,
  input  logic [tot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tot_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [tot_pkg::FIX_W-1:0]  fixed_offset_r;
  logic                       auto_mode_r;
  logic [tot_pkg::SCAN_W-1:0] scan_span_r;
  logic [tot_pkg::WGT_W-1:0]  smoothing_weight_r;
  logic [tot_pkg::DLY_W-1:0]  capture_delay_r;

  // stage links
  logic                       s1_valid;
  logic                       s1_ready;
  tot_pkg::s1_item_t          s1_item;
  logic                       s2_valid;
  logic                       s2_ready;
  tot_pkg::s2_item_t          s2_item;
  tot_pkg::trk_stat_t         trk_stat;
  logic [tot_pkg::DEV_W-1:0]  shifted_time;
  logic                       offset_reseeded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_offset_r     <= tot_pkg::FIXED_OFFSET_RST;
      auto_mode_r        <= 1'b0;
      scan_span_r        <= tot_pkg::SCAN_SPAN_RST;
      smoothing_weight_r <= tot_pkg::SMOOTH_WEIGHT_RST;
      capture_delay_r    <= tot_pkg::CAPTURE_DELAY_RST;
    end else if (cfg_wr_en) begin
      case (tot_pkg::cfg_idx_t'(cfg_index))
        tot_pkg::CFG_FIXED_OFFSET:  fixed_offset_r     <= cfg_data[tot_pkg::FIX_W-1:0];
        tot_pkg::CFG_AUTO_MODE:     auto_mode_r        <= cfg_data[0];
        tot_pkg::CFG_SCAN_SPAN:     scan_span_r        <= cfg_data[tot_pkg::SCAN_W-1:0];
        tot_pkg::CFG_SMOOTH_WEIGHT: smoothing_weight_r <= cfg_data[tot_pkg::WGT_W-1:0];
        tot_pkg::CFG_CAPTURE_DELAY: capture_delay_r    <= cfg_data[tot_pkg::DLY_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // register the item and form the measured offset
  tot_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .scan_span (scan_span_r),
    .nxt_ready (s1_ready),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  // moving average of the offset, restart detection, offset selection
  tot_offset_track u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .s1_item          (s1_item),
    .auto_mode        (auto_mode_r),
    .fixed_offset     (fixed_offset_r),
    .smoothing_weight (smoothing_weight_r),
    .nxt_ready        (s2_ready),
    .s2_valid         (s2_valid),
    .s2_item          (s2_item),
    .stat             (trk_stat)
  );

  // apply offset and capture delay, clamp, hold the result
  tot_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2_valid      (s2_valid),
    .s2_ready      (s2_ready),
    .s2_item       (s2_item),
    .capture_delay (capture_delay_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_time      (shifted_time),
    .out_reseeded  (offset_reseeded)
  );

  assign out_tdata = {{(tot_pkg::OUT_DATA_W-tot_pkg::DEV_W){1'b0}}, shifted_time};
  assign out_tuser = offset_reseeded;

  // the average starts empty after reset
  a_reset_clears_track: assert property (@(posedge clk)
    !rst_n |=> !trk_stat.tracked_valid)
    else $error("tracked offset valid right after reset");

  // first auto-mode item always restarts the average
  a_first_item_reseeds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_ready && auto_mode_r && !trk_stat.tracked_valid) |=> s2_item.reseeded)
    else $error("first tracked item not flagged as reseeded");

  // fixed mode never touches the average
  a_fixed_no_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_ready && !auto_mode_r) |=> !s2_item.reseeded)
    else $error("reseed flagged in fixed mode");

  // a flagged result implies the average holds a value
  a_flag_needs_track: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> trk_stat.tracked_valid)
    else $error("reseed flag without tracked offset");

endmodule
